>>> sv/lsfe_pkg.sv
// lsfe_pkg: shared constants, types and helpers for the lin slave frame engine
// holds the slot entry decode, the command passed front to back and the result record
// no dependencies
package lsfe_pkg;

  localparam int NUM_SLOTS      = 4;
  localparam int MAX_DATA_BYTES = 8;
  localparam int QUEUE_DEPTH    = 4;

  localparam int ENTRY_W       = 14;
  localparam int SLOT_W        = 2;
  localparam int POS_W         = 3;
  localparam int LEN_W         = 4;
  localparam int STORE_DEPTH   = NUM_SLOTS * MAX_DATA_BYTES;
  localparam int STORE_ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]        SYNC_BYTE  = 8'h55;
  localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_DATA_BYTES);
  localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(NUM_SLOTS);

  // item actions
  localparam logic [1:0] ACT_BREAK   = 2'd0;
  localparam logic [1:0] ACT_BUS     = 2'd1;
  localparam logic [1:0] ACT_HOST_WR = 2'd2;
  localparam logic [1:0] ACT_HOST_RD = 2'd3;

  // slot roles
  localparam logic [1:0] ROLE_PUB = 2'd1;
  localparam logic [1:0] ROLE_SUB = 2'd2;

  // frame status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_RX_OK   = 3'd1;
  localparam logic [2:0] ST_CSUM    = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_REJECT  = 3'd4;

  // command kinds
  localparam logic [2:0] CMD_IGNORE    = 3'd0;
  localparam logic [2:0] CMD_PUBLISH   = 3'd1;
  localparam logic [2:0] CMD_SUB_START = 3'd2;
  localparam logic [2:0] CMD_SUB_DATA  = 3'd3;
  localparam logic [2:0] CMD_SUB_CHECK = 3'd4;
  localparam logic [2:0] CMD_HOST_WR   = 3'd5;
  localparam logic [2:0] CMD_HOST_RD   = 3'd6;

  typedef logic [STORE_ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [7:0]        data;
    logic              ok;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        tx_byte;
    logic              tx_valid;
    logic              last;
    logic [7:0]        read_byte;
    logic              read_ok;
    logic [2:0]        frame_status;
    logic [SLOT_W-1:0] status_slot;
  } res_t;

  function automatic logic [7:0] entry_pid(input logic [ENTRY_W-1:0] e);
    return e[7:0];
  endfunction

  function automatic logic [1:0] entry_role(input logic [ENTRY_W-1:0] e);
    return e[13:12];
  endfunction

  // length clamped to 1..MAX_DATA_BYTES
  function automatic logic [LEN_W-1:0] entry_len(input logic [ENTRY_W-1:0] e);
    logic [LEN_W-1:0] n;
    n = e[11:8];
    if (n == '0) n = LEN_W'(1);
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  function automatic addr_t store_addr(input logic [SLOT_W-1:0] slot,
                                       input logic [POS_W-1:0] pos);
    return addr_t'(int'(slot) * MAX_DATA_BYTES + int'(pos));
  endfunction

endpackage

>>> sv/lsfe_front.sv
// lsfe_front: slot table, header receiver and item classification
// turns each accepted item into at most one command for the back end
// depends on lsfe_pkg
module lsfe_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lsfe_pkg::SLOT_W-1:0]       cfg_index,
  input  logic [lsfe_pkg::ENTRY_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [7:0]                        bus_byte,
  input  logic [lsfe_pkg::SLOT_W-1:0]       host_slot,
  input  logic [lsfe_pkg::POS_W-1:0]        host_position,
  input  logic [7:0]                        host_byte,
  input  logic                              q_full,
  output logic                              q_push,
  output lsfe_pkg::cmd_t                    q_cmd
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SYNC = 2'd1;
  localparam logic [1:0] PH_PID  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [lsfe_pkg::ENTRY_W-1:0] slot_entry [lsfe_pkg::NUM_SLOTS];

  logic [1:0]                  phase, phase_next;
  logic [lsfe_pkg::SLOT_W-1:0] active_slot, active_slot_next;
  logic [lsfe_pkg::LEN_W-1:0]  byte_count, byte_count_next;
  logic [7:0]                  running_xor, running_xor_next;

  logic                        accept;
  logic                        pid_hit;
  logic [lsfe_pkg::SLOT_W-1:0] pid_slot;
  logic [lsfe_pkg::LEN_W-1:0]  act_len;
  logic [lsfe_pkg::LEN_W-1:0]  host_len;
  logic [1:0]                  host_role;
  logic                        host_in_range;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lsfe_pkg::NUM_SLOTS; i++) slot_entry[i] <= '0;
    end else if (cfg_write && ({1'b0, cfg_index} < lsfe_pkg::SLOT_LIMIT)) begin
      slot_entry[cfg_index] <= cfg_data;
    end
  end

  // lowest matching slot wins
  always_comb begin
    pid_hit  = 1'b0;
    pid_slot = '0;
    for (int s = lsfe_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
      if ((lsfe_pkg::entry_role(slot_entry[s]) == lsfe_pkg::ROLE_PUB ||
           lsfe_pkg::entry_role(slot_entry[s]) == lsfe_pkg::ROLE_SUB) &&
          lsfe_pkg::entry_pid(slot_entry[s]) == bus_byte) begin
        pid_hit  = 1'b1;
        pid_slot = lsfe_pkg::SLOT_W'(s);
      end
    end
  end

  assign act_len       = lsfe_pkg::entry_len(slot_entry[active_slot]);
  assign host_len      = lsfe_pkg::entry_len(slot_entry[host_slot]);
  assign host_role     = lsfe_pkg::entry_role(slot_entry[host_slot]);
  assign host_in_range = ({1'b0, host_slot} < lsfe_pkg::SLOT_LIMIT) &&
                         ({1'b0, host_position} < host_len);

  always_comb begin
    phase_next       = phase;
    active_slot_next = active_slot;
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    q_push           = 1'b0;
    q_cmd            = '0;
    if (accept) begin
      unique case (action)
        lsfe_pkg::ACT_BREAK: begin
          phase_next       = PH_SYNC;
          byte_count_next  = '0;
          running_xor_next = '0;
        end
        lsfe_pkg::ACT_BUS: begin
          unique case (phase)
            PH_IDLE: begin
            end
            PH_SYNC: begin
              if (bus_byte == lsfe_pkg::SYNC_BYTE) begin
                phase_next = PH_PID;
              end else begin
                phase_next = PH_IDLE;
                q_push     = 1'b1;
                q_cmd.kind = lsfe_pkg::CMD_IGNORE;
              end
            end
            PH_PID: begin
              phase_next = PH_IDLE;
              q_push     = 1'b1;
              q_cmd.slot = pid_slot;
              q_cmd.len  = lsfe_pkg::entry_len(slot_entry[pid_slot]);
              if (!pid_hit) begin
                q_cmd.kind = lsfe_pkg::CMD_IGNORE;
              end else if (lsfe_pkg::entry_role(slot_entry[pid_slot]) ==
                           lsfe_pkg::ROLE_PUB) begin
                q_cmd.kind = lsfe_pkg::CMD_PUBLISH;
              end else begin
                q_cmd.kind       = lsfe_pkg::CMD_SUB_START;
                active_slot_next = pid_slot;
                byte_count_next  = '0;
                running_xor_next = '0;
                phase_next       = PH_DATA;
              end
            end
            PH_DATA: begin
              q_push     = 1'b1;
              q_cmd.slot = active_slot;
              q_cmd.data = bus_byte;
              if (byte_count < act_len) begin
                q_cmd.kind       = lsfe_pkg::CMD_SUB_DATA;
                q_cmd.pos        = byte_count[lsfe_pkg::POS_W-1:0];
                running_xor_next = running_xor ^ bus_byte;
                byte_count_next  = byte_count + lsfe_pkg::LEN_W'(1);
              end else begin
                q_cmd.kind = lsfe_pkg::CMD_SUB_CHECK;
                q_cmd.ok   = (bus_byte == ~running_xor);
                phase_next = PH_IDLE;
              end
            end
          endcase
        end
        lsfe_pkg::ACT_HOST_WR: begin
          q_push     = 1'b1;
          q_cmd.kind = lsfe_pkg::CMD_HOST_WR;
          q_cmd.slot = host_slot;
          q_cmd.pos  = host_position;
          q_cmd.data = host_byte;
          q_cmd.ok   = host_in_range && (host_role == lsfe_pkg::ROLE_PUB);
        end
        lsfe_pkg::ACT_HOST_RD: begin
          q_push     = 1'b1;
          q_cmd.kind = lsfe_pkg::CMD_HOST_RD;
          q_cmd.slot = host_slot;
          q_cmd.pos  = host_position;
          q_cmd.ok   = host_in_range && (host_role == lsfe_pkg::ROLE_SUB);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      active_slot <= '0;
      byte_count  <= '0;
      running_xor <= '0;
    end else begin
      phase       <= phase_next;
      active_slot <= active_slot_next;
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
    end
  end

endmodule

>>> sv/lsfe_cmd_queue.sv
// lsfe_cmd_queue: small fifo of commands between front and back end
// depends on lsfe_pkg
module lsfe_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsfe_pkg::cmd_t push_cmd,
  input  logic           pop,
  output lsfe_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  lsfe_pkg::cmd_t                slots [lsfe_pkg::QUEUE_DEPTH];
  logic [lsfe_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lsfe_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lsfe_pkg::QCNT_W-1:0]   count;

  assign full  = (count == lsfe_pkg::QCNT_W'(lsfe_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + lsfe_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + lsfe_pkg::QPTR_W'(1);
      if (push && !pop)      count <= count + lsfe_pkg::QCNT_W'(1);
      else if (pop && !push) count <= count - lsfe_pkg::QCNT_W'(1);
    end
  end

endmodule

>>> sv/lsfe_back.sv
// lsfe_back: executes commands against the data store and drives the result register
// holds the data store, its written bits and the subscribe valid flags
// depends on lsfe_pkg
module lsfe_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  lsfe_pkg::cmd_t                q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    tx_byte,
  output logic                          tx_valid,
  output logic                          last,
  output logic [7:0]                    read_byte,
  output logic                          read_ok,
  output logic [2:0]                    frame_status,
  output logic [lsfe_pkg::SLOT_W-1:0]   status_slot
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_EXEC = 2'd1;
  localparam logic [1:0] B_CSUM = 2'd2;

  logic [1:0]                    state, state_next;
  lsfe_pkg::cmd_t                cur;
  logic [lsfe_pkg::LEN_W-1:0]    byte_idx, byte_idx_next;
  logic [7:0]                    xor_acc, xor_acc_next;
  logic [lsfe_pkg::NUM_SLOTS-1:0] slot_valid;

  logic [7:0]                    data_mem [lsfe_pkg::STORE_DEPTH];
  logic [lsfe_pkg::STORE_DEPTH-1:0] mem_written;
  logic [7:0]                    rd_data;
  logic                          rd_hit;
  logic                          rd_en;
  lsfe_pkg::addr_t               rd_addr;
  logic                          mem_we;
  lsfe_pkg::addr_t               wr_addr;

  logic                          sv_we;
  logic                          sv_val;
  logic                          out_free;
  logic                          emit;
  lsfe_pkg::res_t                res_next;
  lsfe_pkg::res_t                res_q;
  logic                          out_valid_q;
  logic [7:0]                    mem_byte;
  logic                          rd_granted;
  logic [lsfe_pkg::LEN_W-1:0]    idx_inc;

  assign out_free   = !out_valid_q || !out_stall;
  assign mem_byte   = rd_hit ? rd_data : 8'h00;
  assign rd_granted = cur.ok && slot_valid[cur.slot];
  assign idx_inc    = byte_idx + lsfe_pkg::LEN_W'(1);
  assign wr_addr    = lsfe_pkg::store_addr(cur.slot, cur.pos);

  always_comb begin
    state_next    = state;
    byte_idx_next = byte_idx;
    xor_acc_next  = xor_acc;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = lsfe_pkg::store_addr(q_head.slot, q_head.pos);
    mem_we        = 1'b0;
    sv_we         = 1'b0;
    sv_val        = 1'b0;
    emit          = 1'b0;
    res_next      = '0;
    res_next.last        = 1'b1;
    res_next.status_slot = cur.slot;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          rd_en         = 1'b1;
          byte_idx_next = '0;
          xor_acc_next  = '0;
          state_next    = B_EXEC;
        end
      end
      B_EXEC: begin
        unique case (cur.kind)
          lsfe_pkg::CMD_IGNORE: begin
            res_next.frame_status = lsfe_pkg::ST_IGNORED;
            res_next.status_slot  = '0;
            if (out_free) begin
              emit       = 1'b1;
              state_next = B_IDLE;
            end
          end
          lsfe_pkg::CMD_SUB_START: begin
            sv_we      = 1'b1;
            sv_val     = 1'b0;
            state_next = B_IDLE;
          end
          lsfe_pkg::CMD_SUB_DATA: begin
            mem_we     = 1'b1;
            state_next = B_IDLE;
          end
          lsfe_pkg::CMD_SUB_CHECK: begin
            res_next.frame_status = cur.ok ? lsfe_pkg::ST_RX_OK : lsfe_pkg::ST_CSUM;
            if (out_free) begin
              emit       = 1'b1;
              sv_we      = 1'b1;
              sv_val     = cur.ok;
              state_next = B_IDLE;
            end
          end
          lsfe_pkg::CMD_HOST_WR: begin
            res_next.frame_status = cur.ok ? lsfe_pkg::ST_NONE : lsfe_pkg::ST_REJECT;
            if (out_free) begin
              emit       = 1'b1;
              mem_we     = cur.ok;
              state_next = B_IDLE;
            end
          end
          lsfe_pkg::CMD_HOST_RD: begin
            res_next.read_ok      = rd_granted;
            res_next.read_byte    = rd_granted ? mem_byte : 8'h00;
            res_next.frame_status = rd_granted ? lsfe_pkg::ST_NONE : lsfe_pkg::ST_REJECT;
            if (out_free) begin
              emit       = 1'b1;
              state_next = B_IDLE;
            end
          end
          lsfe_pkg::CMD_PUBLISH: begin
            res_next.tx_byte  = mem_byte;
            res_next.tx_valid = 1'b1;
            res_next.last     = 1'b0;
            // fetch the next byte as this one leaves
            rd_addr = lsfe_pkg::store_addr(cur.slot, idx_inc[lsfe_pkg::POS_W-1:0]);
            if (out_free) begin
              emit          = 1'b1;
              xor_acc_next  = xor_acc ^ mem_byte;
              byte_idx_next = idx_inc;
              if (idx_inc == cur.len) begin
                state_next = B_CSUM;
              end else begin
                rd_en = 1'b1;
              end
            end
          end
          default: begin
            state_next = B_IDLE;
          end
        endcase
      end
      B_CSUM: begin
        res_next.tx_byte  = ~xor_acc;
        res_next.tx_valid = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // data store, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) data_mem[wr_addr] <= cur.data;
    if (rd_en) begin
      rd_data <= data_mem[rd_addr];
      rd_hit  <= mem_written[rd_addr];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_written <= '0;
    end else if (mem_we) begin
      mem_written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (emit)  res_q <= res_next;
    byte_idx <= byte_idx_next;
    xor_acc  <= xor_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      slot_valid  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      if (sv_we) slot_valid[cur.slot] <= sv_val;
      if (emit)            out_valid_q <= 1'b1;
      else if (!out_stall) out_valid_q <= 1'b0;
    end
  end

  assign out_valid    = out_valid_q;
  assign tx_byte      = res_q.tx_byte;
  assign tx_valid     = res_q.tx_valid;
  assign last         = res_q.last;
  assign read_byte    = res_q.read_byte;
  assign read_ok      = res_q.read_ok;
  assign frame_status = res_q.frame_status;
  assign status_slot  = res_q.status_slot;

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_pop_to_exec: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == B_EXEC)
    else $error("popped command not executed next cycle");

  a_csum_publish: assert property (@(posedge clk) disable iff (rst)
    state == B_CSUM |-> cur.kind == lsfe_pkg::CMD_PUBLISH)
    else $error("checksum state outside a publish response");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result register overwritten while held");

  a_tx_not_read: assert property (@(posedge clk) disable iff (rst)
    out_valid_q |-> !(res_q.tx_valid && res_q.read_ok))
    else $error("transmit result also flagged as host read");

endmodule

>>> sv/lin_slave_frame_engine_core.sv
// lin_slave_frame_engine_core: top level of the lin slave frame engine
// joins front end, command queue and back end; depends on lsfe_pkg and the lsfe modules
//
// Usage: items arrive on in_valid/in_stall with action, bus_byte, host_slot,
// host_position and host_byte; results leave on out_valid/out_stall as
// result records. Slot entries are written through cfg_write, cfg_index and
// cfg_data; the user must do so only while the block is idle, as the block
// itself does not enforce it. The front end classifies an item in the cycle
// it is accepted and pushes a command into a four-entry queue; it stalls only
// when that queue is full. The back end pops a command and executes it in the
// next cycle; a publish response gives length + 1 results, paced by the data
// store read at one byte per cycle while the receiver does not stall. With an
// idle queue, an accepted item's command is written into the queue, popped
// and executed by the back end, and its result lands in the result register.
// Reset clears the slot table, phase, queue, valid flags and written bits of
// the data store, so every data byte reads as zero until written.
// When the receiver stalls, the result register holds; the back end keeps
// one result pending and the queue keeps taking items until it fills.
module lin_slave_frame_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lsfe_pkg::SLOT_W-1:0]       cfg_index,
  input  logic [lsfe_pkg::ENTRY_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [7:0]                        bus_byte,
  input  logic [lsfe_pkg::SLOT_W-1:0]       host_slot,
  input  logic [lsfe_pkg::POS_W-1:0]        host_position,
  input  logic [7:0]                        host_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        tx_byte,
  output logic                              tx_valid,
  output logic                              last,
  output logic [7:0]                        read_byte,
  output logic                              read_ok,
  output logic [2:0]                        frame_status,
  output logic [lsfe_pkg::SLOT_W-1:0]       status_slot
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  lsfe_pkg::cmd_t q_cmd;
  lsfe_pkg::cmd_t q_head;

  lsfe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .bus_byte      (bus_byte),
    .host_slot     (host_slot),
    .host_position (host_position),
    .host_byte     (host_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  lsfe_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  lsfe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tx_byte      (tx_byte),
    .tx_valid     (tx_valid),
    .last         (last),
    .read_byte    (read_byte),
    .read_ok      (read_ok),
    .frame_status (frame_status),
    .status_slot  (status_slot)
  );

endmodule

>>> sim/tb_lin_slave_frame_engine_core.sv
`timescale 1ns / 1ps
// tb_lin_slave_frame_engine_core: self-checking bench for the lin slave frame engine core
// predicts every result from the accepted items and slot table; depends on lsfe_pkg and the core
module tb_lin_slave_frame_engine_core;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_PRINTS    = 100;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 28;

  localparam logic [1:0] ROLE_NONE  = 2'd0;
  localparam logic [1:0] ROLE_SPARE = 2'd3;

  typedef enum logic [1:0] {HDR_IDLE, HDR_SYNC, HDR_PID, HDR_DATA} hdr_phase_t;

  logic                         clk           = 1'b0;
  logic                         rst           = 1'b1;
  logic                         cfg_write     = 1'b0;
  logic [lsfe_pkg::SLOT_W-1:0]  cfg_index     = '0;
  logic [lsfe_pkg::ENTRY_W-1:0] cfg_data      = '0;
  logic                         in_valid      = 1'b0;
  logic                         in_stall;
  logic [1:0]                   action        = lsfe_pkg::ACT_BREAK;
  logic [7:0]                   bus_byte      = '0;
  logic [lsfe_pkg::SLOT_W-1:0]  host_slot     = '0;
  logic [lsfe_pkg::POS_W-1:0]   host_position = '0;
  logic [7:0]                   host_byte     = '0;
  logic                         out_valid;
  logic                         out_stall     = 1'b0;
  logic [7:0]                   tx_byte;
  logic                         tx_valid;
  logic                         last;
  logic [7:0]                   read_byte;
  logic                         read_ok;
  logic [2:0]                   frame_status;
  logic [lsfe_pkg::SLOT_W-1:0]  status_slot;

  // shadow of the engine
  logic [lsfe_pkg::ENTRY_W-1:0] slot_cfg [lsfe_pkg::NUM_SLOTS];
  hdr_phase_t                   hdr_phase   = HDR_IDLE;
  logic [lsfe_pkg::SLOT_W-1:0]  rx_slot     = '0;
  logic [3:0]                   rx_count    = '0;
  logic [7:0]                   rx_xor      = '0;
  logic [7:0]                   shadow_store [lsfe_pkg::STORE_DEPTH];
  logic                         sub_valid [lsfe_pkg::NUM_SLOTS];
  lsfe_pkg::res_t               lin_results [$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int pub_frames   = 0;
  int sub_frames   = 0;
  int cfg_settings = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int stall_mode   = 0;
  int stall_run    = 0;
  lsfe_pkg::res_t want;

  lin_slave_frame_engine_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .bus_byte(bus_byte), .host_slot(host_slot),
    .host_position(host_position), .host_byte(host_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_byte(tx_byte), .tx_valid(tx_valid), .last(last),
    .read_byte(read_byte), .read_ok(read_ok),
    .frame_status(frame_status), .status_slot(status_slot)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < lsfe_pkg::NUM_SLOTS; i++) begin
      slot_cfg[i]  = '0;
      sub_valid[i] = 1'b0;
    end
    for (int i = 0; i < lsfe_pkg::STORE_DEPTH; i++) shadow_store[i] = '0;
  end

  function automatic logic [1:0] slot_role(input logic [lsfe_pkg::SLOT_W-1:0] s);
    return slot_cfg[s][13:12];
  endfunction

  function automatic logic [7:0] slot_pid(input logic [lsfe_pkg::SLOT_W-1:0] s);
    return slot_cfg[s][7:0];
  endfunction

  // zero length counts as one, anything past the store width as the maximum
  function automatic logic [3:0] slot_len(input logic [lsfe_pkg::SLOT_W-1:0] s);
    logic [3:0] n;
    n = slot_cfg[s][11:8];
    if (n == 4'd0) n = 4'd1;
    if (n > lsfe_pkg::MAX_DATA_BYTES) n = 4'(lsfe_pkg::MAX_DATA_BYTES);
    return n;
  endfunction

  function automatic logic [lsfe_pkg::ENTRY_W-1:0] slot_word(input logic [1:0] role,
                                                             input logic [3:0] len,
                                                             input logic [7:0] pid);
    return {role, len, pid};
  endfunction

  function automatic logic [lsfe_pkg::ENTRY_W-1:0] random_slot_word();
    int r;
    logic [1:0] role;
    r = $urandom_range(0, 7);
    role = (r == 0) ? ROLE_NONE : (r < 4) ? lsfe_pkg::ROLE_PUB :
           (r < 7) ? lsfe_pkg::ROLE_SUB : ROLE_SPARE;
    // a shared pid now and then so that slot priority matters
    return slot_word(role, 4'($urandom_range(0, 15)),
                     ($urandom_range(0, 2) == 0) ? 8'h3C : 8'($urandom_range(0, 255)));
  endfunction

  task automatic owe_result(input logic [7:0] tx, input logic txv, input logic lst,
                            input logic [7:0] rb, input logic rok, input logic [2:0] st,
                            input logic [lsfe_pkg::SLOT_W-1:0] sl);
    lsfe_pkg::res_t r;
    r.tx_byte      = tx;
    r.tx_valid     = txv;
    r.last         = lst;
    r.read_byte    = rb;
    r.read_ok      = rok;
    r.frame_status = st;
    r.status_slot  = sl;
    lin_results.push_back(r);
  endtask

  task automatic advance_lin_state(input logic [1:0] act, input logic [7:0] bb,
                                   input logic [lsfe_pkg::SLOT_W-1:0] hs,
                                   input logic [lsfe_pkg::POS_W-1:0] hp,
                                   input logic [7:0] hb);
    int s;
    int i;
    int hit;
    logic [lsfe_pkg::SLOT_W-1:0] hit_slot;
    logic [7:0] sum;
    logic [7:0] d;
    hit = -1;
    hit_slot = '0;
    case (act)
      lsfe_pkg::ACT_BREAK: begin
        hdr_phase = HDR_SYNC;
        rx_count  = '0;
        rx_xor    = '0;
      end
      lsfe_pkg::ACT_BUS: begin
        case (hdr_phase)
          HDR_SYNC: begin
            if (bb == lsfe_pkg::SYNC_BYTE) begin
              hdr_phase = HDR_PID;
            end else begin
              hdr_phase = HDR_IDLE;
              owe_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, lsfe_pkg::ST_IGNORED, '0);
            end
          end
          HDR_PID: begin
            hdr_phase = HDR_IDLE;
            // scan downwards so the lowest matching slot is kept
            for (s = lsfe_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
              if ((slot_role(lsfe_pkg::SLOT_W'(s)) == lsfe_pkg::ROLE_PUB ||
                   slot_role(lsfe_pkg::SLOT_W'(s)) == lsfe_pkg::ROLE_SUB) &&
                  slot_pid(lsfe_pkg::SLOT_W'(s)) == bb)
                hit = s;
            end
            if (hit >= 0) hit_slot = lsfe_pkg::SLOT_W'(hit);
            if (hit < 0) begin
              owe_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, lsfe_pkg::ST_IGNORED, '0);
            end else if (slot_role(hit_slot) == lsfe_pkg::ROLE_PUB) begin
              sum = '0;
              for (i = 0; i < slot_len(hit_slot); i++) begin
                d = shadow_store[hit_slot * lsfe_pkg::MAX_DATA_BYTES + i];
                sum = sum ^ d;
                owe_result(d, 1'b1, 1'b0, 8'h00, 1'b0, lsfe_pkg::ST_NONE, hit_slot);
              end
              owe_result(~sum, 1'b1, 1'b1, 8'h00, 1'b0, lsfe_pkg::ST_NONE, hit_slot);
              pub_frames++;
            end else begin
              rx_slot             = hit_slot;
              rx_count            = '0;
              rx_xor              = '0;
              sub_valid[hit_slot] = 1'b0;
              hdr_phase           = HDR_DATA;
            end
          end
          HDR_DATA: begin
            // length is looked up afresh on every byte
            if (rx_count < slot_len(rx_slot)) begin
              shadow_store[rx_slot * lsfe_pkg::MAX_DATA_BYTES + rx_count] = bb;
              rx_xor   = rx_xor ^ bb;
              rx_count = rx_count + 4'd1;
            end else begin
              hdr_phase = HDR_IDLE;
              sub_valid[rx_slot] = (bb == ~rx_xor);
              owe_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0,
                         sub_valid[rx_slot] ? lsfe_pkg::ST_RX_OK : lsfe_pkg::ST_CSUM,
                         rx_slot);
              sub_frames++;
            end
          end
          default: ;
        endcase
      end
      lsfe_pkg::ACT_HOST_WR: begin
        if (slot_role(hs) == lsfe_pkg::ROLE_PUB && hp < slot_len(hs)) begin
          shadow_store[hs * lsfe_pkg::MAX_DATA_BYTES + hp] = hb;
          owe_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, lsfe_pkg::ST_NONE, hs);
        end else begin
          owe_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, lsfe_pkg::ST_REJECT, hs);
        end
      end
      default: begin
        if (slot_role(hs) == lsfe_pkg::ROLE_SUB && sub_valid[hs] && hp < slot_len(hs))
          owe_result(8'h00, 1'b0, 1'b1, shadow_store[hs * lsfe_pkg::MAX_DATA_BYTES + hp],
                     1'b1, lsfe_pkg::ST_NONE, hs);
        else
          owe_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, lsfe_pkg::ST_REJECT, hs);
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("result %0d %s: got %0h, predicted %0h",
                                results_seen, name, got, exp_v));
  endtask

  // sender: bursts of random length with random gaps, some bursts back to back
  task automatic send_item(input logic [1:0] act, input logic [7:0] bb,
                           input logic [lsfe_pkg::SLOT_W-1:0] hs,
                           input logic [lsfe_pkg::POS_W-1:0] hp,
                           input logic [7:0] hb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    action        <= act;
    bus_byte      <= bb;
    host_slot     <= hs;
    host_position <= hp;
    host_byte     <= hb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_lin_state(act, bb, hs, hp, hb);
    items_sent++;
  endtask

  task automatic send_break();
    send_item(lsfe_pkg::ACT_BREAK, 8'($urandom), 2'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic send_bus(input logic [7:0] b);
    send_item(lsfe_pkg::ACT_BUS, b, 2'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic send_host_wr(input logic [lsfe_pkg::SLOT_W-1:0] s,
                              input logic [lsfe_pkg::POS_W-1:0] p,
                              input logic [7:0] b);
    send_item(lsfe_pkg::ACT_HOST_WR, 8'($urandom), s, p, b);
  endtask

  task automatic send_host_rd(input logic [lsfe_pkg::SLOT_W-1:0] s,
                              input logic [lsfe_pkg::POS_W-1:0] p);
    send_item(lsfe_pkg::ACT_HOST_RD, 8'($urandom), s, p, 8'($urandom));
  endtask

  // wait for every result, then let queued no-result items drain
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (lin_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_slots(input logic [lsfe_pkg::ENTRY_W-1:0] e0,
                               input logic [lsfe_pkg::ENTRY_W-1:0] e1,
                               input logic [lsfe_pkg::ENTRY_W-1:0] e2,
                               input logic [lsfe_pkg::ENTRY_W-1:0] e3);
    logic [lsfe_pkg::ENTRY_W-1:0] e [lsfe_pkg::NUM_SLOTS];
    int i;
    e = '{e0, e1, e2, e3};
    for (i = 0; i < lsfe_pkg::NUM_SLOTS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= lsfe_pkg::SLOT_W'(i);
      cfg_data  <= e[i];
      @(posedge clk);
      slot_cfg[i] = e[i];
    end
    cfg_write <= 1'b0;
    cfg_settings++;
  endtask

  // header, then data and checksum while the engine is collecting, with breaks and host accesses mixed in
  task automatic run_frame(input logic [lsfe_pkg::SLOT_W-1:0] s, input bit good_sum);
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(slot_pid(s));
    while (hdr_phase == HDR_DATA) begin
      case ($urandom_range(0, 24))
        0: send_break();
        1: send_host_rd(2'($urandom), 3'($urandom));
        2: send_host_wr(2'($urandom), 3'($urandom), 8'($urandom));
        default: begin
          if (rx_count < slot_len(rx_slot))
            send_bus(8'($urandom));
          else
            send_bus(good_sum ? ~rx_xor : 8'($urandom));
        end
      endcase
    end
  endtask

  // reset slot table: bus byte while idle, bad sync, pid with no slot
  task automatic test_header_rejects();
    send_bus(8'hFF);
    send_break();
    send_bus(8'hAA);
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(8'h00);
  endtask

  task automatic test_publish_response();
    settle_idle();
    program_slots(slot_word(lsfe_pkg::ROLE_PUB, 4'd15, 8'hC1),
                  slot_word(lsfe_pkg::ROLE_SUB, 4'd8, 8'hC1),
                  slot_word(ROLE_SPARE, 4'd2, 8'h00),
                  slot_word(lsfe_pkg::ROLE_SUB, 4'd0, 8'h00));
    send_host_wr(2'd0, 3'd7, 8'hFF);
    send_host_wr(2'd1, 3'd0, 8'h12);
    // slot 0 wins over slot 1, length clamped to eight
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(8'hC1);
  endtask

  task automatic test_subscribe_frames();
    // slot 2 has the spare role, so pid 00 lands on slot 3 with length one
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(8'h00);
    send_bus(8'hA5);
    send_bus(8'h5A);
    send_host_rd(2'd3, 3'd0);
    send_host_rd(2'd3, 3'd1);
    // interrupted frame, then a frame with a bad checksum
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(8'h00);
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(8'h00);
    send_bus(8'h11);
    send_bus(8'h00);
    send_host_rd(2'd3, 3'd0);
  endtask

  // length cut short mid frame: the next byte is taken as checksum
  task automatic test_length_change();
    settle_idle();
    program_slots(slot_word(lsfe_pkg::ROLE_PUB, 4'd8, 8'hC1),
                  slot_word(lsfe_pkg::ROLE_SUB, 4'd8, 8'h42),
                  slot_word(ROLE_SPARE, 4'd2, 8'h00),
                  slot_word(lsfe_pkg::ROLE_SUB, 4'd0, 8'h00));
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(8'h42);
    send_bus(8'h11);
    send_bus(8'h22);
    settle_idle();
    program_slots(slot_word(lsfe_pkg::ROLE_PUB, 4'd8, 8'hC1),
                  slot_word(lsfe_pkg::ROLE_SUB, 4'd2, 8'h42),
                  slot_word(ROLE_SPARE, 4'd2, 8'h00),
                  slot_word(lsfe_pkg::ROLE_SUB, 4'd0, 8'h00));
    send_bus(8'hCC);
    send_host_rd(2'd1, 3'd1);
  endtask

  task automatic test_config_extremes();
    settle_idle();
    program_slots(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(8'hFF);
    settle_idle();
    program_slots('0, '0, '0, '0);
    send_break();
    send_bus(lsfe_pkg::SYNC_BYTE);
    send_bus(8'h00);
  endtask

  task automatic test_random_traffic();
    int ph;
    int pick;
    int target;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_idle();
      program_slots(random_slot_word(), random_slot_word(), random_slot_word(),
                    random_slot_word());
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          run_frame(2'($urandom), $urandom_range(0, 4) != 0);
        end else if (pick < 13) begin
          send_host_wr(2'($urandom), 3'($urandom), 8'($urandom));
        end else if (pick < 16) begin
          send_host_rd(2'($urandom), 3'($urandom));
        end else if (pick < 18) begin
          send_item(2'($urandom), 8'($urandom), 2'($urandom), 3'($urandom), 8'($urandom));
        end else begin
          // broken header
          send_break();
          send_bus(($urandom_range(0, 1) == 0) ? lsfe_pkg::SYNC_BYTE : 8'($urandom));
        end
      end
    end
  endtask

  // receiver stall pattern: free running, light, heavy and periodic stretches
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(4, 40);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ((stall_run % 5) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (lin_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = lin_results.pop_front();
        check_field("tx_byte", tx_byte, want.tx_byte);
        check_field("tx_valid", 8'(tx_valid), 8'(want.tx_valid));
        check_field("last", 8'(last), 8'(want.last));
        check_field("read_byte", read_byte, want.read_byte);
        check_field("read_ok", 8'(read_ok), 8'(want.read_ok));
        check_field("frame_status", 8'(frame_status), 8'(want.frame_status));
        check_field("status_slot", 8'(status_slot), 8'(want.status_slot));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, lin_results.size());
      $display("lin_slave_frame_engine_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_header_rejects();
    test_publish_response();
    test_subscribe_frames();
    test_length_change();
    test_config_extremes();
    test_random_traffic();
    in_valid <= 1'b0;
    while (lin_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items over %0d slot table settings, %0d results checked",
             items_sent, cfg_settings, results_seen);
    $display("%0d publish responses and %0d subscribe frames closed, %0d mismatches",
             pub_frames, sub_frames, errors);
    if (errors == 0)
      $display("lin_slave_frame_engine_core: match");
    else
      $display("lin_slave_frame_engine_core: mismatch");
    $finish;
  end

endmodule
